### hw/rtl/dhcp_reply_parser_top_assert.svh
// Assertion macros shared by the parser modules.
`ifndef DHCP_REPLY_PARSER_TOP_ASSERT_SVH
`define DHCP_REPLY_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define DHCP_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

`define DHCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define DHCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define DHCP_ASSERT(lbl, clk, rst_n, expr)
`define DHCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DHCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/dhcp_pkg.sv
package dhcp_pkg;

	localparam int HEADER_LEN = 240;
	localparam int OP_OFS = 0;
	localparam int XID_OFS = 4;
	localparam int YADDR_OFS = 16;
	localparam int COOKIE_OFS = HEADER_LEN - 4;

	localparam logic [7:0] BOOT_REPLY = 8'd2;
	localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

	localparam logic [7:0] OPT_PAD = 8'd0;
	localparam logic [7:0] OPT_END = 8'd255;
	localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
	localparam logic [7:0] TYPE_NAK = 8'd6;

	localparam int NUM_WORDS = 6;
	localparam logic [7:0] WORD_CODES [NUM_WORDS] = '{8'd0, 8'd1, 8'd3, 8'd6, 8'd54, 8'd51};

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_XID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE = 2'd1;
	localparam logic [7:0] WANTED_TYPE_RST = 8'd2;

	typedef enum logic [1:0] {
		ST_IGNORED = 2'd0,
		ST_ACCEPTED = 2'd1,
		ST_NAK = 2'd2,
		ST_ZERO_ADDR = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] packet_byte;
		logic last_byte;
	} packet_beat_t;

	typedef struct packed {
		status_t status;
		logic [7:0] message_type;
		logic [31:0] your_addr;
		logic [31:0] subnet_mask;
		logic [31:0] router_addr;
		logic [31:0] dns_addr;
		logic [31:0] server_id;
		logic [31:0] lease_seconds;
	} reply_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic hdr_err;
		logic is_yaddr;
		logic is_opt;
		logic long_enough;
	} class_beat_t;

	function automatic logic [7:0] byte_sel(input logic [31:0] word, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = word[31:24];
			2'd1: b = word[23:16];
			2'd2: b = word[15:8];
			default: b = word[7:0];
		endcase
		return b;
	endfunction

endpackage

### hw/rtl/dhcp_front.sv
module dhcp_front #(
	parameter int PACKET_CAP = 548
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input dhcp_pkg::packet_beat_t packet_beat,
	input logic [31:0] expected_xid,
	output dhcp_pkg::class_beat_t beat
);

	localparam int OFS_W = $clog2(PACKET_CAP + 1);

	logic [OFS_W-1:0] offset_q;
	logic kept;
	logic [7:0] b;

	assign b = packet_beat.packet_byte;
	assign kept = offset_q < OFS_W'(PACKET_CAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (accept) begin
			if (packet_beat.last_byte) begin
				offset_q <= '0;
			end else if (kept) begin
				offset_q <= offset_q + 1'b1;
			end
		end
	end

	always_comb begin
		beat = '0;
		beat.data = b;
		beat.last = packet_beat.last_byte;
		beat.long_enough = offset_q >= OFS_W'(dhcp_pkg::HEADER_LEN - 1);
		beat.is_opt = kept && (offset_q >= OFS_W'(dhcp_pkg::HEADER_LEN));
		beat.is_yaddr = (offset_q >= OFS_W'(dhcp_pkg::YADDR_OFS))
			&& (offset_q < OFS_W'(dhcp_pkg::YADDR_OFS + 4));
		if (offset_q == OFS_W'(dhcp_pkg::OP_OFS) && b != dhcp_pkg::BOOT_REPLY) begin
			beat.hdr_err = 1'b1;
		end
		if (offset_q >= OFS_W'(dhcp_pkg::XID_OFS) && offset_q < OFS_W'(dhcp_pkg::XID_OFS + 4)
			&& b != dhcp_pkg::byte_sel(expected_xid, offset_q[1:0])) begin
			beat.hdr_err = 1'b1;
		end
		if (offset_q >= OFS_W'(dhcp_pkg::COOKIE_OFS)
			&& offset_q < OFS_W'(dhcp_pkg::HEADER_LEN)
			&& b != dhcp_pkg::byte_sel(dhcp_pkg::MAGIC_COOKIE, offset_q[1:0])) begin
			beat.hdr_err = 1'b1;
		end
	end

endmodule

### hw/rtl/dhcp_beat_fifo.sv
`include "dhcp_reply_parser_top_assert.svh"

module dhcp_beat_fifo #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input dhcp_pkg::class_beat_t wr_beat,
	output logic full,
	input logic rd_en,
	output logic avail,
	output dhcp_pkg::class_beat_t rd_beat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	dhcp_pkg::class_beat_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = count_q == CNT_W'(DEPTH);
	assign avail = count_q != '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && avail;
	assign rd_beat = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_beat;
		end
	end

	`DHCP_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_W'(DEPTH))
	`DHCP_ASSERT_NXT(a_count_up, clk, arst_n, do_wr && !do_rd, count_q == $past(count_q) + 1'b1)
	`DHCP_ASSERT_NXT(a_count_down, clk, arst_n, do_rd && !do_wr, count_q == $past(count_q) - 1'b1)
	`DHCP_ASSERT_IMP(a_ptr_match, clk, arst_n, count_q == '0 || full, wr_ptr_q == rd_ptr_q)

endmodule

### hw/rtl/dhcp_back.sv
`include "dhcp_reply_parser_top_assert.svh"

module dhcp_back (
	input logic clk,
	input logic arst_n,
	input logic avail,
	input dhcp_pkg::class_beat_t beat,
	output logic take,
	input logic [7:0] wanted_type,
	input logic pop,
	output logic empty,
	output dhcp_pkg::reply_result_t reply_result
);

	typedef enum logic [1:0] {
		PH_CODE,
		PH_LEN,
		PH_VALUE,
		PH_DONE
	} phase_t;

	phase_t phase_q, phase_n;
	logic [7:0] code_q, code_n;
	logic [7:0] left_q, left_n;
	logic [7:0] cnt_q, cnt_n;
	logic [31:0] shift_q, shift_n;
	logic [7:0] first_q, first_n;
	logic hg_q, hg_n;
	logic [31:0] words_q [dhcp_pkg::NUM_WORDS];
	logic [31:0] words_n [dhcp_pkg::NUM_WORDS];
	logic [7:0] ctype_q, ctype_n;
	logic [dhcp_pkg::NUM_WORDS-1:0] flags_q, flags_n;
	logic out_valid_q;
	dhcp_pkg::reply_result_t out_q, result;
	logic [7:0] t;
	logic [7:0] b;
	logic last_take;
	logic mid_take;
	logic ign_out;
	logic blank_out;

	assign b = beat.data;
	assign take = avail && (!beat.last || !out_valid_q || pop);
	assign empty = !out_valid_q;
	assign reply_result = out_q;
	assign last_take = take && beat.last;
	assign mid_take = take && !beat.last;
	assign ign_out = out_valid_q && out_q.status == dhcp_pkg::ST_IGNORED;
	assign blank_out = out_q.message_type == 8'd0 && out_q.your_addr == 32'd0;

	always_comb begin
		phase_n = phase_q;
		code_n = code_q;
		left_n = left_q;
		cnt_n = cnt_q;
		shift_n = shift_q;
		first_n = first_q;
		hg_n = hg_q & ~beat.hdr_err;
		words_n = words_q;
		ctype_n = ctype_q;
		flags_n = flags_q;
		if (beat.is_yaddr) begin
			words_n[0] = {words_q[0][23:0], b};
		end
		if (beat.is_opt) begin
			case (phase_q)
				PH_CODE: begin
					if (b == dhcp_pkg::OPT_END) begin
						phase_n = PH_DONE;
					end else if (b != dhcp_pkg::OPT_PAD) begin
						code_n = b;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					left_n = b;
					cnt_n = '0;
					shift_n = '0;
					phase_n = (b == 8'd0) ? PH_CODE : PH_VALUE;
				end
				PH_VALUE: begin
					if (cnt_q < 8'd4) begin
						shift_n = {shift_q[23:0], b};
					end
					if (cnt_q == 8'd0) begin
						first_n = b;
					end
					cnt_n = cnt_q + 8'd1;
					left_n = left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_n = PH_CODE;
						if (code_q == dhcp_pkg::OPT_MSG_TYPE && !flags_q[0]) begin
							ctype_n = first_n;
							flags_n[0] = 1'b1;
						end
						if (cnt_n == 8'd4) begin
							for (int k = 1; k < dhcp_pkg::NUM_WORDS; k++) begin
								if (code_q == dhcp_pkg::WORD_CODES[k] && !flags_q[k]) begin
									words_n[k] = shift_n;
									flags_n[k] = 1'b1;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		t = flags_n[0] ? ctype_n : 8'd0;
		result = '0;
		result.status = dhcp_pkg::ST_IGNORED;
		if (beat.long_enough && hg_n) begin
			if (t == wanted_type) begin
				result.status = (words_n[0] != 32'd0) ? dhcp_pkg::ST_ACCEPTED
					: dhcp_pkg::ST_ZERO_ADDR;
			end else if (t == dhcp_pkg::TYPE_NAK) begin
				result.status = dhcp_pkg::ST_NAK;
			end
		end
		if (result.status != dhcp_pkg::ST_IGNORED) begin
			result.message_type = t;
			result.your_addr = words_n[0];
			result.subnet_mask = words_n[1];
			result.router_addr = words_n[2];
			result.dns_addr = words_n[3];
			result.server_id = words_n[4];
			result.lease_seconds = words_n[5];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CODE;
			code_q <= '0;
			left_q <= '0;
			cnt_q <= '0;
			shift_q <= '0;
			first_q <= '0;
			hg_q <= 1'b1;
			for (int k = 0; k < dhcp_pkg::NUM_WORDS; k++) begin
				words_q[k] <= '0;
			end
			ctype_q <= '0;
			flags_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (last_take) begin
				phase_q <= PH_CODE;
				code_q <= '0;
				left_q <= '0;
				cnt_q <= '0;
				shift_q <= '0;
				first_q <= '0;
				hg_q <= 1'b1;
				for (int k = 0; k < dhcp_pkg::NUM_WORDS; k++) begin
					words_q[k] <= '0;
				end
				ctype_q <= '0;
				flags_q <= '0;
				out_valid_q <= 1'b1;
				out_q <= result;
			end else begin
				if (pop && out_valid_q) begin
					out_valid_q <= 1'b0;
				end
				if (take) begin
					phase_q <= phase_n;
					code_q <= code_n;
					left_q <= left_n;
					cnt_q <= cnt_n;
					shift_q <= shift_n;
					first_q <= first_n;
					hg_q <= hg_n;
					words_q <= words_n;
					ctype_q <= ctype_n;
					flags_q <= flags_n;
				end
			end
		end
	end

	`DHCP_ASSERT_NXT(a_last_fills, clk, arst_n, last_take, out_valid_q && flags_q == '0 && hg_q)
	`DHCP_ASSERT_IMP(a_ignored_blank, clk, arst_n, ign_out, blank_out)
	`DHCP_ASSERT_NXT(a_done_holds, clk, arst_n, mid_take && phase_q == PH_DONE, phase_q == PH_DONE)
	`DHCP_ASSERT_IMP(a_type_flag, clk, arst_n, !flags_q[0], ctype_q == 8'd0)

endmodule

### hw/rtl/dhcp_reply_parser_top.sv
// DHCPv4 reply parser.
// Input channel: one packet byte per beat (packet_beat), with last_byte set on
// the final byte of a reply. A beat is taken on a clock edge with push high
// and full low. Up to one byte per cycle is accepted while full stays low.
// Result channel: one reply_result per packet, presented while empty is low
// and taken on an edge with pop high. The result of a packet is registered
// in the result slot once the back stage takes its last byte from the queue.
// A front stage tags each byte by its offset and checks op, xid and cookie;
// a beat queue of DEPTH entries feeds the back stage, which walks the options
// and builds the result. While a result waits to be popped, bytes of the next
// packet keep flowing; the back stage holds only at the next last byte, and
// the input reports full once the queue fills up.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index
// (0 expected xid, 1 wanted message type); other indexes are
// dropped. Write only while no packet is in flight.
// Reset (arst_n low) empties the queue and result slot and returns the
// registers to xid 0 and wanted type 2.
module dhcp_reply_parser_top #(
	parameter int PACKET_CAP = 548,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input dhcp_pkg::packet_beat_t packet_beat,
	output logic empty,
	input logic pop,
	output dhcp_pkg::reply_result_t reply_result,
	input logic cfg_wr_en,
	input logic [dhcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	logic [31:0] expected_xid_q;
	logic [7:0] wanted_type_q;
	logic accept;
	logic avail;
	logic take;
	dhcp_pkg::class_beat_t front_beat;
	dhcp_pkg::class_beat_t back_beat;

	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_xid_q <= '0;
			wanted_type_q <= dhcp_pkg::WANTED_TYPE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dhcp_pkg::CFG_EXPECTED_XID: expected_xid_q <= cfg_data;
				dhcp_pkg::CFG_WANTED_TYPE: wanted_type_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	dhcp_front #(
		.PACKET_CAP(PACKET_CAP)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.packet_beat(packet_beat),
		.expected_xid(expected_xid_q),
		.beat(front_beat)
	);

	dhcp_beat_fifo #(
		.DEPTH(DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(push),
		.wr_beat(front_beat),
		.full(full),
		.rd_en(take),
		.avail(avail),
		.rd_beat(back_beat)
	);

	dhcp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.avail(avail),
		.beat(back_beat),
		.take(take),
		.wanted_type(wanted_type_q),
		.pop(pop),
		.empty(empty),
		.reply_result(reply_result)
	);

endmodule
